FILE: rtl/aprc_pkg.sv
// Shared types, kind codes and saturation helper for the AABB pair resolver.
package aprc_pkg;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_STATIC  = 2'd1,
        KIND_DYNAMIC = 2'd2,
        KIND_TRIGGER = 2'd3
    } kind_t;

    typedef struct packed {
        logic signed [31:0] a_left;
        logic signed [31:0] a_top;
        logic        [30:0] a_width;
        logic        [30:0] a_height;
        logic signed [31:0] b_left;
        logic signed [31:0] b_top;
        logic        [30:0] b_width;
        logic        [30:0] b_height;
        kind_t              a_kind;
        kind_t              b_kind;
    } pair_word_t;

    typedef struct packed {
        logic               pair_reported;
        logic               normal_on_y;
        logic               normal_negative;
        logic signed [31:0] depth;
        logic signed [31:0] a_move_x;
        logic signed [31:0] a_move_y;
        logic signed [31:0] b_move_x;
        logic signed [31:0] b_move_y;
    } result_word_t;

    // edges, doubled centers and size sums of both rectangles
    typedef struct packed {
        logic               hit;
        logic               report;
        logic               move_en;
        kind_t              a_kind;
        kind_t              b_kind;
        logic signed [31:0] a_left;
        logic signed [31:0] b_left;
        logic signed [31:0] a_top;
        logic signed [31:0] b_top;
        logic signed [32:0] a_right;
        logic signed [32:0] b_right;
        logic signed [32:0] a_bottom;
        logic signed [32:0] b_bottom;
        logic signed [33:0] a_mid_x;
        logic signed [33:0] b_mid_x;
        logic signed [33:0] a_mid_y;
        logic signed [33:0] b_mid_y;
        logic        [31:0] w_sum;
        logic        [31:0] h_sum;
    } geom_t;

    // chosen normal and exact depth
    typedef struct packed {
        logic               hit;
        logic               report;
        logic               move_en;
        kind_t              a_kind;
        kind_t              b_kind;
        logic               on_y;
        logic               neg;
        logic signed [33:0] depth;
    } axis_t;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [34:0] hi;
        logic signed [34:0] lo;
        hi = {{3{SAT_MAX[31]}}, SAT_MAX};
        lo = {{3{SAT_MIN[31]}}, SAT_MIN};
        if (v > hi)
            return SAT_MAX;
        else if (v < lo)
            return SAT_MIN;
        else
            return v[31:0];
    endfunction

endpackage

FILE: rtl/aprc_ifs.sv
// Valid/ready channel interfaces for pair and result words.
interface aprc_pair_if;
    logic                valid;
    logic                ready;
    aprc_pkg::pair_word_t word;

    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

interface aprc_result_if;
    logic                  valid;
    logic                  ready;
    aprc_pkg::result_word_t word;

    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

FILE: rtl/aprc_stage_geom.sv
// Stage one: edges, overlap test, report and move enables, doubled centers.
module aprc_stage_geom (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  aprc_pkg::pair_word_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output aprc_pkg::geom_t      out_data
);

    logic            valid_reg;
    aprc_pkg::geom_t data_reg;
    aprc_pkg::geom_t data_next;
    logic signed [32:0] a_left_x;
    logic signed [32:0] b_left_x;
    logic signed [32:0] a_top_x;
    logic signed [32:0] b_top_x;

    always_comb
    begin
        a_left_x = {in_data.a_left[31], in_data.a_left};
        b_left_x = {in_data.b_left[31], in_data.b_left};
        a_top_x  = {in_data.a_top[31], in_data.a_top};
        b_top_x  = {in_data.b_top[31], in_data.b_top};

        data_next.a_kind   = in_data.a_kind;
        data_next.b_kind   = in_data.b_kind;
        data_next.a_left   = in_data.a_left;
        data_next.b_left   = in_data.b_left;
        data_next.a_top    = in_data.a_top;
        data_next.b_top    = in_data.b_top;
        data_next.a_right  = a_left_x + $signed({2'b00, in_data.a_width});
        data_next.b_right  = b_left_x + $signed({2'b00, in_data.b_width});
        data_next.a_bottom = a_top_x + $signed({2'b00, in_data.a_height});
        data_next.b_bottom = b_top_x + $signed({2'b00, in_data.b_height});
        data_next.a_mid_x  = $signed({in_data.a_left[31], in_data.a_left, 1'b0})
                           + $signed({3'b000, in_data.a_width});
        data_next.b_mid_x  = $signed({in_data.b_left[31], in_data.b_left, 1'b0})
                           + $signed({3'b000, in_data.b_width});
        data_next.a_mid_y  = $signed({in_data.a_top[31], in_data.a_top, 1'b0})
                           + $signed({3'b000, in_data.a_height});
        data_next.b_mid_y  = $signed({in_data.b_top[31], in_data.b_top, 1'b0})
                           + $signed({3'b000, in_data.b_height});
        data_next.w_sum    = {1'b0, in_data.a_width} + {1'b0, in_data.b_width};
        data_next.h_sum    = {1'b0, in_data.a_height} + {1'b0, in_data.b_height};

        data_next.hit = (a_left_x < data_next.b_right) && (data_next.a_right > b_left_x)
                     && (a_top_x < data_next.b_bottom) && (data_next.a_bottom > b_top_x);
        data_next.report = !((in_data.a_kind == aprc_pkg::KIND_STATIC)
                          && (in_data.b_kind == aprc_pkg::KIND_STATIC));
        data_next.move_en = (in_data.a_kind != aprc_pkg::KIND_NONE)
                         && (in_data.b_kind != aprc_pkg::KIND_NONE)
                         && (in_data.a_kind != aprc_pkg::KIND_TRIGGER)
                         && (in_data.b_kind != aprc_pkg::KIND_TRIGGER);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

FILE: rtl/aprc_stage_axis.sv
// Stage two: center differences, doubled overlaps, normal choice and depth.
module aprc_stage_axis (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  aprc_pkg::geom_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output aprc_pkg::axis_t out_data
);

    logic            valid_reg;
    aprc_pkg::axis_t data_reg;
    aprc_pkg::axis_t data_next;
    logic signed [34:0] dx2;
    logic signed [34:0] dy2;
    logic signed [34:0] adx;
    logic signed [34:0] ady;
    logic signed [35:0] ox2;
    logic signed [35:0] oy2;
    logic signed [33:0] depth_xp;
    logic signed [33:0] depth_xn;
    logic signed [33:0] depth_yp;
    logic signed [33:0] depth_yn;

    always_comb
    begin
        dx2 = {in_data.b_mid_x[33], in_data.b_mid_x} - {in_data.a_mid_x[33], in_data.a_mid_x};
        dy2 = {in_data.b_mid_y[33], in_data.b_mid_y} - {in_data.a_mid_y[33], in_data.a_mid_y};
        adx = dx2[34] ? -dx2 : dx2;
        ady = dy2[34] ? -dy2 : dy2;
        ox2 = $signed({4'b0000, in_data.w_sum}) - {adx[34], adx};
        oy2 = $signed({4'b0000, in_data.h_sum}) - {ady[34], ady};

        depth_xp = {in_data.a_right[32], in_data.a_right}
                 - {{2{in_data.b_left[31]}}, in_data.b_left};
        depth_xn = {in_data.b_right[32], in_data.b_right}
                 - {{2{in_data.a_left[31]}}, in_data.a_left};
        depth_yp = {in_data.a_bottom[32], in_data.a_bottom}
                 - {{2{in_data.b_top[31]}}, in_data.b_top};
        depth_yn = {in_data.b_bottom[32], in_data.b_bottom}
                 - {{2{in_data.a_top[31]}}, in_data.a_top};

        data_next.hit     = in_data.hit;
        data_next.report  = in_data.report;
        data_next.move_en = in_data.move_en;
        data_next.a_kind  = in_data.a_kind;
        data_next.b_kind  = in_data.b_kind;
        data_next.on_y    = !(ox2 < oy2);
        data_next.neg     = data_next.on_y ? dy2[34] : dx2[34];
        if (data_next.on_y)
            data_next.depth = data_next.neg ? depth_yn : depth_yp;
        else
            data_next.depth = data_next.neg ? depth_xn : depth_xp;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

FILE: rtl/aprc_stage_resolve.sv
// Stage three: position corrections, saturation and the result register.
module aprc_stage_resolve (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  aprc_pkg::axis_t        in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output aprc_pkg::result_word_t out_data
);

    logic                   valid_reg;
    aprc_pkg::result_word_t data_reg;
    aprc_pkg::result_word_t data_next;
    logic signed [34:0] depth_x;
    logic signed [34:0] depth_signed;
    logic signed [34:0] half_x;
    logic signed [34:0] half_signed;
    logic signed [34:0] move_a;
    logic signed [34:0] move_b;
    logic signed [31:0] sat_a;
    logic signed [31:0] sat_b;

    always_comb
    begin
        depth_x      = {in_data.depth[33], in_data.depth};
        depth_signed = in_data.neg ? -depth_x : depth_x;
        half_x       = depth_x >>> 1;
        half_signed  = in_data.neg ? -half_x : half_x;

        if (in_data.a_kind == aprc_pkg::KIND_STATIC)
        begin
            move_a = '0;
            move_b = depth_signed;
        end
        else if (in_data.b_kind == aprc_pkg::KIND_STATIC)
        begin
            move_a = -depth_signed;
            move_b = '0;
        end
        else
        begin
            move_a = -half_signed;
            move_b = half_signed;
        end

        sat_a = in_data.move_en ? aprc_pkg::sat32(move_a) : '0;
        sat_b = in_data.move_en ? aprc_pkg::sat32(move_b) : '0;

        data_next = '0;
        if (in_data.hit && in_data.report)
        begin
            data_next.pair_reported   = 1'b1;
            data_next.normal_on_y     = in_data.on_y;
            data_next.normal_negative = in_data.neg;
            data_next.depth           = aprc_pkg::sat32(depth_x);
            if (in_data.on_y)
            begin
                data_next.a_move_y = sat_a;
                data_next.b_move_y = sat_b;
            end
            else
            begin
                data_next.a_move_x = sat_a;
                data_next.b_move_x = sat_b;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

endmodule

FILE: rtl/aabb_pair_collision_resolve.sv
// Top level: input register and three stages of AABB pair collision resolution.
// Latency: an accepted pair word passes the input, geom, axis and resolve registers before its result word is valid.
// Throughput: one pair word per cycle; each stage holds one word and stalls only
// while the stage after it is full and not draining.
// Reset: rst_n clears every valid flag at once; payload registers are not reset.
module aabb_pair_collision_resolve (
    input  logic          clk,
    input  logic          rst_n,
    aprc_pair_if.sink     pair,
    aprc_result_if.source result
);

    logic                 in_valid_reg;
    aprc_pkg::pair_word_t in_data_reg;
    logic                 geom_ready;
    logic                 geom_valid;
    aprc_pkg::geom_t      geom_data;
    logic                 axis_ready;
    logic                 axis_valid;
    aprc_pkg::axis_t      axis_data;
    logic                 res_ready;

    assign pair.ready = !in_valid_reg || geom_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (pair.ready)
            in_valid_reg <= pair.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pair.valid && pair.ready)
            in_data_reg <= pair.word;
    end

    aprc_stage_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_ready  (geom_ready),
        .in_data   (in_data_reg),
        .out_valid (geom_valid),
        .out_ready (axis_ready),
        .out_data  (geom_data)
    );

    aprc_stage_axis u_axis (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geom_valid),
        .in_ready  (axis_ready),
        .in_data   (geom_data),
        .out_valid (axis_valid),
        .out_ready (res_ready),
        .out_data  (axis_data)
    );

    aprc_stage_resolve u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (axis_valid),
        .in_ready  (res_ready),
        .in_data   (axis_data),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (result.word)
    );

    // an unreported pair carries an all-zero word
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.word.pair_reported |->
            result.word.depth == '0 && result.word.a_move_x == '0
            && result.word.a_move_y == '0 && result.word.b_move_x == '0
            && result.word.b_move_y == '0 && !result.word.normal_on_y
            && !result.word.normal_negative)
        else $error("unreported pair has nonzero fields");

    // with the normal on x, the y moves are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.word.normal_on_y |->
            result.word.a_move_y == '0 && result.word.b_move_y == '0)
        else $error("move off the x normal axis");

    // a reported overlap always has positive depth
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.word.pair_reported |-> result.word.depth > 0)
        else $error("reported pair without positive depth");

    // a held input word is not dropped while the first stage stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !geom_ready |=> in_valid_reg && $stable(in_data_reg))
        else $error("input register lost a stalled word");

endmodule
